### rtl/core/wrf_pkg.sv
// Shared types, constants and helper functions for the wall repulsion force block.
// Depends on nothing; wrf_lane, wall_repulsion_force and wrf_checker refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package wrf_pkg;

  // Default fractional width of the force results.
  localparam int FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HARDNESS = 2'd1;

  localparam logic [23:0] HARDNESS_RESET = 24'd65536;

  // 1.122462 in Q1.30: range limit of the wall potential relative to the radius.
  localparam logic [30:0] REACH_Q30 = 31'd1205234395;

  // Widths of the fixed-point chain.
  localparam int DEN_W   = 25;  // distance in range is below 2^25
  localparam int Q_BITS  = 35;  // r/d in Q32, below 8.0
  localparam int INT_BITS = 14; // integer part of the force before the cap
  localparam int MUL_LAT = 3;   // register stages of the split multiplier

  // Per-item classification that travels down each lane.
  typedef enum logic [1:0] {
    KIND_CALC = 2'd0,
    KIND_CAP  = 2'd1,
    KIND_ZERO = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [31:0] body_x;
    logic signed [31:0] flagella_x;
    logic [23:0]        body_radius;
    logic [23:0]        flagella_radius;
  } in_t;

  typedef struct packed {
    logic [29:0] body_force;
    logic [29:0] flagella_force;
  } out_t;

  // Force cap: 10000 in Q(fb), clipped to the 30-bit result range.
  function automatic logic [29:0] force_cap(int fb);
    logic [63:0] raw;
    raw = 64'd10000 << fb;
    return (raw < 64'h3FFF_FFFF) ? raw[29:0] : 30'h3FFF_FFFF;
  endfunction

  // Cycles from an accepted request to its result strobe.
  function automatic int pipe_latency(int fb);
    return 2 + Q_BITS + 5 * MUL_LAT + 1 + 1 + (INT_BITS + fb) + 1;
  endfunction

endpackage

`default_nettype wire

### rtl/core/wrf_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none

module wrf_div #(
  parameter int DW = 25,
  parameter int QW = 35,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic [DW-1:0] rem_i,  // upper numerator part, must be below den_i
  input  wire logic [QW-1:0] num_i,  // lower numerator bits, shifted in MSB first
  input  wire logic [DW-1:0] den_i,
  input  wire logic [TW-1:0] tag_i,
  output logic      [QW-1:0] quo_o,
  output logic      [TW-1:0] tag_o
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] nq_r  [QW];   // numerator bits leave at the top, quotient bits enter below
  logic [DW-1:0] den_r [QW];
  logic [TW-1:0] tag_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] nq_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   trial;
    logic [DW-1:0] diff;
    logic          take;
    logic [DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign nq_in  = num_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign tag_in = tag_r[k-1];
    end

    // When the subtraction is taken the difference is below den_in, so DW bits hold it.
    assign trial   = {rem_in, nq_in[QW-1]};
    assign diff    = trial[DW-1:0] - den_in;
    assign take    = (trial >= {1'b0, den_in});
    assign rem_nxt = take ? diff : trial[DW-1:0];

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      nq_r[k]  <= {nq_in[QW-2:0], take};
      den_r[k] <= den_in;
      tag_r[k] <= tag_in;
    end
  end

  assign quo_o = nq_r[QW-1];
  assign tag_o = tag_r[QW-1];

endmodule

`default_nettype wire

### rtl/core/wrf_mul.sv
// Three-stage multiplier built from four half-width partial products.
// Returns the product shifted right by SH and truncated to WO bits.
`timescale 1ns / 1ps
`default_nettype none

module wrf_mul #(
  parameter int WA = 35,
  parameter int WB = 35,
  parameter int SH = 32,
  parameter int WO = 38,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic [WA-1:0] a_i,
  input  wire logic [WB-1:0] b_i,
  input  wire logic [TW-1:0] tag_i,
  output logic      [WO-1:0] prod_o,
  output logic      [TW-1:0] tag_o
);

  localparam int AL = WA / 2;
  localparam int AH = WA - AL;
  localparam int BL = WB / 2;
  localparam int BH = WB - BL;
  localparam int PW = WA + WB;

  logic [AL+BL-1:0] p00_r;
  logic [AL+BH-1:0] p01_r;
  logic [AH+BL-1:0] p10_r;
  logic [AH+BH-1:0] p11_r;
  logic [PW-1:0]    lo_r;
  logic [PW-1:0]    hi_r;
  logic [PW-1:0]    full_nxt;
  logic [WO-1:0]    prod_r;
  logic [TW-1:0]    tag_r [3];

  assign full_nxt = lo_r + (hi_r << AL);

  always_ff @(posedge clk) begin
    p00_r <= (AL+BL)'(a_i[AL-1:0])  * (AL+BL)'(b_i[BL-1:0]);
    p01_r <= (AL+BH)'(a_i[AL-1:0])  * (AL+BH)'(b_i[WB-1:BL]);
    p10_r <= (AH+BL)'(a_i[WA-1:AL]) * (AH+BL)'(b_i[BL-1:0]);
    p11_r <= (AH+BH)'(a_i[WA-1:AL]) * (AH+BH)'(b_i[WB-1:BL]);
    lo_r  <= PW'(p00_r) + (PW'(p01_r) << BL);
    hi_r  <= PW'(p10_r) + (PW'(p11_r) << BL);
    prod_r <= WO'(full_nxt >> SH);
    tag_r[0] <= tag_i;
    tag_r[1] <= tag_r[0];
    tag_r[2] <= tag_r[1];
  end

  assign prod_o = prod_r;
  assign tag_o  = tag_r[2];

endmodule

`default_nettype wire

### rtl/core/wrf_lane.sv
// One force lane: distance, range test, r/d divider, power chain, scaling divider.
// Depends on wrf_pkg, wrf_div and wrf_mul.
`timescale 1ns / 1ps
`default_nettype none

module wrf_lane #(
  parameter int FRAC_BITS = wrf_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic [31:0] pos_i,
  input  wire logic [23:0] rad_i,
  input  wire logic [31:0] wall_x_i,
  input  wire logic [23:0] hard_i,
  output logic      [29:0] force_o
);

  localparam int DW = wrf_pkg::DEN_W;
  localparam int QB = wrf_pkg::Q_BITS;
  localparam int FW = wrf_pkg::INT_BITS + FRAC_BITS;
  localparam logic [29:0] CAP = wrf_pkg::force_cap(FRAC_BITS);
  localparam logic [50:0] ONE_Q32 = 51'd1 << 32;

  typedef struct packed {
    wrf_pkg::kind_t kind;
    logic [DW-1:0]  ud;
    logic [28:0]    h24;
  } ctx_t;

  typedef struct packed {
    ctx_t        c;
    logic [37:0] q2;
  } ctx_q2_t;

  typedef struct packed {
    wrf_pkg::kind_t kind;
    logic [DW-1:0]  ud;
  } ctx_p_t;

  // Stage 1: signed distance to the wall.
  logic signed [32:0] d_r;
  logic [23:0]        r_r;

  always_ff @(posedge clk) begin
    d_r <= {pos_i[31], pos_i} - {wall_x_i[31], wall_x_i};
    r_r <= rad_i;
  end

  // Stage 2: classify the item and set up the r/d division.
  logic [31:0]       ud_full;
  logic              d_pos;
  logic              out_range;
  logic              close;
  ctx_t              ctx_nxt;
  ctx_t              ctx_r;
  logic [DW-1:0]     qrem_r;
  logic [QB-1:0]     qnum_r;

  assign ud_full   = d_r[31:0];
  assign d_pos     = !d_r[32] && (d_r != '0);
  assign out_range = ({ud_full, 30'b0} >= 62'(62'(r_r) * 62'(wrf_pkg::REACH_Q30)));
  assign close     = (35'(r_r) >= {ud_full, 3'b0});

  always_comb begin
    ctx_nxt.ud  = ud_full[DW-1:0];
    ctx_nxt.h24 = 29'(hard_i) * 29'd24;
    if (!d_pos) begin
      ctx_nxt.kind = wrf_pkg::KIND_CAP;
    end else if (out_range || hard_i == '0) begin
      ctx_nxt.kind = wrf_pkg::KIND_ZERO;
    end else if (close) begin
      ctx_nxt.kind = wrf_pkg::KIND_CAP;
    end else begin
      ctx_nxt.kind = wrf_pkg::KIND_CALC;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r  <= ctx_nxt;
    qrem_r <= DW'(r_r[23:3]);
    qnum_r <= {r_r[2:0], 32'b0};
  end

  // q = r / d in Q32.
  logic [QB-1:0] q;
  ctx_t          ctx_q;

  wrf_div #(.DW(DW), .QW(QB), .TW($bits(ctx_t))) u_div_q (
    .clk   (clk),
    .rem_i (qrem_r),
    .num_i (qnum_r),
    .den_i (ctx_r.ud),
    .tag_i (ctx_r),
    .quo_o (q),
    .tag_o (ctx_q)
  );

  // Power chain q^2, q^4, q^6.
  logic [37:0] q2;
  ctx_t        ctx_2;
  logic [43:0] q4;
  ctx_q2_t     ctx_4;
  logic [49:0] q6;
  ctx_t        ctx_6;

  wrf_mul #(.WA(QB), .WB(QB), .SH(32), .WO(38), .TW($bits(ctx_t))) u_mul_q2 (
    .clk(clk), .a_i(q), .b_i(q), .tag_i(ctx_q), .prod_o(q2), .tag_o(ctx_2)
  );

  wrf_mul #(.WA(38), .WB(38), .SH(32), .WO(44), .TW($bits(ctx_q2_t))) u_mul_q4 (
    .clk(clk), .a_i(q2), .b_i(q2), .tag_i({ctx_2, q2}), .prod_o(q4), .tag_o(ctx_4)
  );

  wrf_mul #(.WA(44), .WB(38), .SH(32), .WO(50), .TW($bits(ctx_t))) u_mul_q6 (
    .clk(clk), .a_i(q4), .b_i(ctx_4.q2), .tag_i(ctx_4.c), .prod_o(q6), .tag_o(ctx_6)
  );

  // 2*q^6 - 1; a result not above zero means no force.
  logic [50:0] dbl;
  ctx_t        ctx_t_nxt;
  ctx_t        ctx_t_r;
  logic [49:0] q6_r;
  logic [50:0] tm_r;

  assign dbl = {q6, 1'b0};

  always_comb begin
    ctx_t_nxt = ctx_6;
    if (ctx_6.kind == wrf_pkg::KIND_CALC && dbl <= ONE_Q32) begin
      ctx_t_nxt.kind = wrf_pkg::KIND_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    ctx_t_r <= ctx_t_nxt;
    q6_r    <= q6;
    tm_r    <= dbl - ONE_Q32;
  end

  // g = q^6 * (2q^6 - 1) in Q16, then p = 24 * h * g.
  logic [52:0] g;
  ctx_t        ctx_g;
  logic [65:0] p;
  ctx_p_t      ctx_p;

  wrf_mul #(.WA(50), .WB(51), .SH(48), .WO(53), .TW($bits(ctx_t))) u_mul_g (
    .clk(clk), .a_i(q6_r), .b_i(tm_r), .tag_i(ctx_t_r), .prod_o(g), .tag_o(ctx_g)
  );

  wrf_mul #(.WA(29), .WB(53), .SH(16), .WO(66), .TW($bits(ctx_p_t))) u_mul_p (
    .clk(clk), .a_i(ctx_g.h24), .b_i(g), .tag_i({ctx_g.kind, ctx_g.ud}),
    .prod_o(p), .tag_o(ctx_p)
  );

  // A quotient of 10000 or more saturates; otherwise p is below 10000 * d.
  logic [38:0]    lim;
  wrf_pkg::kind_t kind_c_nxt;
  wrf_pkg::kind_t kind_c_r;
  logic [DW-1:0]  ud_c_r;
  logic [DW-1:0]  frem_r;
  logic [FW-1:0]  fnum_r;

  assign lim = 39'(ctx_p.ud) * 39'd10000;

  always_comb begin
    kind_c_nxt = ctx_p.kind;
    if (ctx_p.kind == wrf_pkg::KIND_CALC && p >= 66'(lim)) begin
      kind_c_nxt = wrf_pkg::KIND_CAP;
    end
  end

  always_ff @(posedge clk) begin
    kind_c_r <= kind_c_nxt;
    ud_c_r   <= ctx_p.ud;
    frem_r   <= p[38:14];
    fnum_r   <= {p[13:0], {FRAC_BITS{1'b0}}};
  end

  // f = p * 2^FRAC_BITS / d.
  logic [FW-1:0]                      f;
  logic [$bits(wrf_pkg::kind_t)-1:0] kind_f;

  wrf_div #(.DW(DW), .QW(FW), .TW($bits(wrf_pkg::kind_t))) u_div_f (
    .clk   (clk),
    .rem_i (frem_r),
    .num_i (fnum_r),
    .den_i (ud_c_r),
    .tag_i (kind_c_r),
    .quo_o (f),
    .tag_o (kind_f)
  );

  // Output select and clip.
  logic [29:0] force_nxt;
  logic [29:0] force_r;

  always_comb begin
    case (kind_f)
      wrf_pkg::KIND_CAP:  force_nxt = CAP;
      wrf_pkg::KIND_ZERO: force_nxt = '0;
      default:            force_nxt = (64'(f) > 64'(CAP)) ? CAP : 30'(f);
    endcase
  end

  always_ff @(posedge clk) begin
    force_r <= force_nxt;
  end

  assign force_o = force_r;

endmodule

`default_nettype wire

### rtl/core/wall_repulsion_force.sv
// Throughput: one request per cycle unless busy; both lanes fully pipelined, never stall.
// The depth is set by the two bit-per-stage dividers (35 stages for r/d, 14 + FRAC_BITS for
// the final scaling) and five three-stage multipliers. The receiver cannot stall results.
// Reset (rst_n low, synchronous) clears all in-flight requests and sets wall_x to 0 and
// hardness to 1.0; busy and cfg_ready are high/low in reset and until rdy_r is set after it.
`timescale 1ns / 1ps
`default_nettype none

module wall_repulsion_force #(
  parameter int FRAC_BITS = wrf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Request channel.
  input  wire logic                          start,
  output logic                               busy,
  input  wire wrf_pkg::in_t                  in_data,
  // Result channel.
  output logic                               out_valid,
  output wrf_pkg::out_t                      out_data,
  // Configuration write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [wrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  localparam int LAT = wrf_pkg::pipe_latency(FRAC_BITS);

  // The block is ready from the cycle after reset is released.
  logic rdy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= 1'b0;
    end else begin
      rdy_r <= 1'b1;
    end
  end

  assign busy      = ~rdy_r;
  assign cfg_ready = rdy_r;

  // Configuration registers. Writes to unknown indexes are dropped.
  logic [31:0] wall_x_r;
  logic [23:0] hard_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_x_r <= '0;
      hard_r   <= wrf_pkg::HARDNESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wrf_pkg::REG_WALL_X:   wall_x_r <= cfg_data;
        wrf_pkg::REG_HARDNESS: hard_r   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // A valid bit per pipeline stage runs alongside the two data lanes; the
  // lanes themselves carry no control state and advance every cycle.
  logic           accept;
  logic [LAT-1:0] vld_r;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  assign out_valid = vld_r[LAT-1];

  // The body and the flagella each get an identical lane.
  wrf_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_body (
    .clk      (clk),
    .pos_i    (in_data.body_x),
    .rad_i    (in_data.body_radius),
    .wall_x_i (wall_x_r),
    .hard_i   (hard_r),
    .force_o  (out_data.body_force)
  );

  wrf_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_flag (
    .clk      (clk),
    .pos_i    (in_data.flagella_x),
    .rad_i    (in_data.flagella_radius),
    .wall_x_i (wall_x_r),
    .hard_i   (hard_r),
    .force_o  (out_data.flagella_force)
  );

endmodule

`default_nettype wire

### rtl/core/wrf_checker.sv
// Port-level checks for wall_repulsion_force, attached by the bind below.
// Depends on wrf_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module wrf_checker #(
  parameter int FRAC_BITS = wrf_pkg::FRAC_BITS_DEF
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire wrf_pkg::out_t out_data
);

  localparam int LAT = wrf_pkg::pipe_latency(FRAC_BITS);
  localparam logic [29:0] CAP = wrf_pkg::force_cap(FRAC_BITS);

  // Every accepted request yields a result after the fixed latency.
  a_req_to_res: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request produced no result");

  // No result appears without a request the fixed latency earlier.
  a_res_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without request");

  a_body_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.body_force <= CAP))
    else $error("body force above cap");

  a_flag_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.flagella_force <= CAP))
    else $error("flagella force above cap");

endmodule

bind wall_repulsion_force wrf_checker #(.FRAC_BITS(FRAC_BITS)) u_wrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire

### verif/wall_repulsion_force_tb.sv
// Self-checking testbench for the wall repulsion force block (wall_repulsion_force).
// Depends on wrf_pkg and the block's RTL; computes the expected forces itself in fixed point.
`timescale 1ns / 1ps

module wall_repulsion_force_tb;

  localparam int FB = 16;
  localparam int LATENCY = 69 + FB;
  localparam int STALL_LIMIT = 4000;
  localparam logic [29:0] CAP = 30'(64'd10000 << FB);
  localparam logic [62:0] ONE_Q32 = 63'd1 << 32;
  localparam logic [63:0] SAT_LIM = 64'd1 << 62;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  wrf_pkg::in_t in_data = '0;
  logic out_valid;
  wrf_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [wrf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  wall_repulsion_force #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The predictor keeps its own copy of the two registers.
  logic signed [63:0] model_wall;
  logic [23:0] model_hard;

  wrf_pkg::out_t pending_forces[$];
  int errors = 0;
  int idle_cycles = 0;
  int sent = 0;
  int checked = 0;
  int idle_pct = 0;

  // Truncating a*b >> s with saturation at 2^62, as the fixed-point chain expects.
  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] prod;
    logic [127:0] shifted;
    prod = a * b;
    shifted = prod >> s;
    return (shifted > SAT_LIM) ? SAT_LIM : shifted[63:0];
  endfunction

  // Expected force on one particle at position pos with radius rad.
  function automatic logic [29:0] lj_wall_force(logic signed [31:0] pos, logic [23:0] rad);
    logic signed [63:0] d;
    logic [63:0] ud, q, q2, q4, q6, g, p, quot, rem, f;
    logic [127:0] lhs, rhs;
    d = 64'(pos) - model_wall;
    if (d <= 0) return CAP;
    ud = d;
    lhs = 128'(ud) << 30;
    rhs = 128'(rad) * 128'(wrf_pkg::REACH_Q30);
    if (lhs >= rhs) return '0;
    if (model_hard == 0) return '0;
    q = (64'(rad) << 32) / ud;
    if (q >= (64'd8 << 32)) return CAP;
    q2 = mul_shift(q, q, 32);
    q4 = mul_shift(q2, q2, 32);
    q6 = mul_shift(q4, q2, 32);
    if (2 * q6 <= 64'(ONE_Q32)) return '0;
    g = mul_shift(q6, 2 * q6 - 64'(ONE_Q32), 48);
    p = mul_shift(64'd24 * 64'(model_hard), g, 16);
    quot = p / ud;
    rem = p % ud;
    if (quot >= 64'd10000) return CAP;
    f = (quot << FB) + ((rem << FB) / ud);
    return (f > 64'(CAP)) ? CAP : f[29:0];
  endfunction

  // Results are checked at every rising edge; a strobe with nothing pending is a failure.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_forces.size() == 0) begin
        $error("unexpected result: body_force %0d flagella_force %0d",
               out_data.body_force, out_data.flagella_force);
        errors++;
      end else begin
        wrf_pkg::out_t want;
        want = pending_forces.pop_front();
        checked++;
        if (out_data.body_force !== want.body_force) begin
          $error("body_force: expected %0d, got %0d", want.body_force, out_data.body_force);
          errors++;
        end
        if (out_data.flagella_force !== want.flagella_force) begin
          $error("flagella_force: expected %0d, got %0d",
                 want.flagella_force, out_data.flagella_force);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no request, result or register write moves.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired with %0d results pending", pending_forces.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Sends one request, predicting its result at the accepting edge. start stays high
  // afterwards so that requests can follow back to back; idling or draining drops it.
  task automatic send_request(wrf_pkg::in_t item);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    begin
      wrf_pkg::out_t want;
      want.body_force = lj_wall_force(item.body_x, item.body_radius);
      want.flagella_force = lj_wall_force(item.flagella_x, item.flagella_radius);
      pending_forces.push_back(want);
    end
    sent++;
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected result is back, then lets the pipeline run empty.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_forces.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_register(logic [wrf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == wrf_pkg::REG_WALL_X) model_wall = 64'(signed'(val));
    else if (idx == wrf_pkg::REG_HARDNESS) model_hard = val[23:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic wrf_pkg::in_t make_item(logic [31:0] bx, logic [31:0] fx,
                                             logic [23:0] br, logic [23:0] fr);
    wrf_pkg::in_t it;
    it.body_x = bx;
    it.flagella_x = fx;
    it.body_radius = br;
    it.flagella_radius = fr;
    return it;
  endfunction

  // A position whose distance to the wall mostly lies inside the interaction range.
  function automatic logic [31:0] near_position(logic [23:0] rad);
    logic [63:0] span;
    span = (64'(rad) * 9) / 8 + 2;
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return 32'(model_wall - $urandom_range(200, 0));
      default: return 32'(model_wall + 64'($urandom_range(32'(span), 1)));
    endcase
  endfunction

  function automatic logic [23:0] pick_radius();
    case ($urandom_range(3, 0))
      0: return 24'($urandom());
      1: return 24'($urandom_range(32'h1_0000, 1));
      default: return 24'($urandom_range(32'h4_0000, 32'h2000));
    endcase
  endfunction

  // Directed items: field extremes, contact, zero radius, very close, edge of range.
  task automatic test_directed();
    send_request(make_item(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 24'h0));
    send_request(make_item(32'h0, 32'hFFFF_FFFF, 24'h1_0000, 24'hFF_FFFF));
    send_request(make_item(32'h1, 32'h100, 24'hFF_FFFF, 24'h1_0000));
    send_request(make_item(32'h1_0000, 32'h1_1F5A, 24'h1_0000, 24'h1_0000));
    send_request(make_item(32'h1_1F5B, 32'h1_1F59, 24'h1_0000, 24'h1_0000));
    send_request(make_item(32'h1_2000, 32'h1_8000, 24'h1_0000, 24'h1_0000));
    send_request(make_item(32'h2000, 32'h1FFF, 24'h1_0000, 24'h1_0000));
    send_request(make_item(32'h00FF_FFFF, 32'h0100_0000, 24'hFF_FFFF, 24'hFF_FFFF));
    send_request(make_item(32'h7FFF_FFFF, 32'h7FFF_0000, 24'h0, 24'h0));
  endtask

  // Each register is swept through extremes and typical values.
  task automatic test_registers();
    write_register(wrf_pkg::REG_HARDNESS, 32'h0);
    send_request(make_item(32'h1_0000, 32'h0, 24'h1_0000, 24'h1_0000));
    send_request(make_item(32'h100, 32'h1, 24'hFF_FFFF, 24'h10));
    write_register(wrf_pkg::REG_HARDNESS, 32'hFF_FFFF);
    send_request(make_item(32'h1_0000, 32'h1_1000, 24'h1_0000, 24'h1_0000));
    write_register(wrf_pkg::REG_WALL_X, 32'h8000_0000);
    send_request(make_item(32'h8000_0000, 32'h8000_0001, 24'h1, 24'h1_0000));
    send_request(make_item(32'h7FFF_FFFF, 32'h8001_0000, 24'hFF_FFFF, 24'h1_0000));
    write_register(wrf_pkg::REG_WALL_X, 32'h7FFF_FFFF);
    send_request(make_item(32'h7FFF_FFFF, 32'h0, 24'hFF_FFFF, 24'h1_0000));
    // An index past the last register must change nothing.
    write_register(2'd3, 32'h1234_5678);
    send_request(make_item(32'h7FFF_FFFF, 32'h8000_0000, 24'h1, 24'h1));
    write_register(wrf_pkg::REG_WALL_X, 32'h0);
    write_register(wrf_pkg::REG_HARDNESS, 32'(wrf_pkg::HARDNESS_RESET));
  endtask

  // Random items, mostly near the wall, under one register setting.
  task automatic test_random(int count, int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      logic [23:0] br, fr;
      br = pick_radius();
      fr = pick_radius();
      send_request(make_item(near_position(br), near_position(fr), br, fr));
      // Let the pipeline run dry once in a while.
      if ($urandom_range(199, 0) == 0) drain_results();
    end
    idle_pct = 0;
  endtask

  task automatic test_settings_sweep();
    write_register(wrf_pkg::REG_WALL_X, 32'hFFF6_0000);
    write_register(wrf_pkg::REG_HARDNESS, 32'h0_4000);
    test_random(400, 15);
    write_register(wrf_pkg::REG_WALL_X, $urandom());
    write_register(wrf_pkg::REG_HARDNESS, $urandom_range(32'hFF_FFFF, 0));
    test_random(400, 69);
    write_register(wrf_pkg::REG_WALL_X, 32'h0030_0000);
    write_register(wrf_pkg::REG_HARDNESS, 32'hFF_FFFF);
    test_random(400, 0);
    write_register(wrf_pkg::REG_WALL_X, 32'h0);
    write_register(wrf_pkg::REG_HARDNESS, 32'(wrf_pkg::HARDNESS_RESET));
    test_random(380, 0);
  endtask

  initial begin
    model_wall = 0;
    model_hard = wrf_pkg::HARDNESS_RESET;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_registers();
    test_settings_sweep();
    drain_results();
    $display("Sent %0d requests, checked %0d results across several wall and hardness settings,",
             sent, checked);
    $display("covering contact, out-of-range, very-close and field-extreme cases.");
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
